// ===== rtl/core/rational_arith_reduce_macros.svh =====
// Assertion macros shared by the rational arithmetic block.
`ifndef RATIONAL_ARITH_REDUCE_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational_arith_reduce: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define RAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational_arith_reduce: next-cycle check failed");
`else
`define RAR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RAR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/rar_pkg.sv =====
// Shared types and constants for the rational arithmetic block.
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int NUM_OUT_W         = 33;
    localparam int DEN_OUT_W         = 32;
    localparam int CMD_W             = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    // Operand pairs for the shared multiplier.
    typedef enum logic [1:0] {
        MSEL_NUM   = 2'd0,
        MSEL_DEN   = 2'd1,
        MSEL_CROSS = 2'd2
    } msel_t;

    // Operand pairs for the shared divider.
    typedef enum logic [1:0] {
        DSEL_GCD = 2'd0,
        DSEL_NUM = 2'd1,
        DSEL_DEN = 2'd2
    } dsel_t;

    typedef struct packed {
        logic  load;
        logic  mul_en;
        msel_t mul_sel;
        logic  set_num;
        logic  set_den;
        logic  acc;
        logic  chk_zero;
        logic  gcd_init;
        logic  div_start;
        dsel_t div_sel;
        logic  div_take;
        logic  out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_zero;
        logic x_zero;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/rar_divider.sv =====
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
module rar_divider #(
    parameter int DIV_WIDTH = 2 * rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0] divisor,
    output logic                 done,
    output logic [DIV_WIDTH-1:0] quotient,
    output logic [DIV_WIDTH-1:0] remainder
);

    localparam int CW = $clog2(DIV_WIDTH + 1);

    logic [DIV_WIDTH-1:0] quo_reg, quo_next;
    logic [DIV_WIDTH-1:0] rem_reg, rem_next;
    logic [DIV_WIDTH-1:0] dvsr_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_WIDTH:0]   shifted;
    logic [DIV_WIDTH:0]   trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_WIDTH-1]};
        trial     = shifted - {1'b0, dvsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(DIV_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // A clear top bit of the trial difference means the divisor fits.
            if (!trial[DIV_WIDTH])
            begin
                rem_next = trial[DIV_WIDTH-1:0];
                quo_next = {quo_reg[DIV_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_WIDTH-1:0];
                quo_next = {quo_reg[DIV_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvsr_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/rar_datapath.sv =====
// Datapath: operand capture, shared multiplier, Euclid registers, divider and output register.
module rar_datapath
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dp_cmd_t                         cmd,
    output dp_stat_t                        stat,
    input  logic [CMD_W-1:0]                command,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic signed [NUM_OUT_W-1:0]     res_num,
    output logic signed [DEN_OUT_W-1:0]     res_den,
    output logic                            div_zero
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int XW = (MW > NUM_OUT_W) ? MW : NUM_OUT_W;
    localparam int YW = (MW > DEN_OUT_W) ? MW : DEN_OUT_W;
    localparam logic [W-1:0]  ONE_W  = W'(1);
    localparam logic [MW-1:0] ONE_MW = MW'(1);

    // Operands in sign-magnitude form.
    logic [W-1:0]  an_raw, ad_raw, bn_raw, bd_raw;
    logic [W-1:0]  an_mag_in, ad_mag_in, bn_mag_in, bd_mag_in;
    cmd_t          cmd_reg;
    logic          an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [W-1:0]  an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;

    logic          op_a_neg, op_b_neg;
    logic [W-1:0]  op_a_mag, op_b_mag;
    logic          prod_neg_reg, prod_nz_reg;
    logic [MW-1:0] prod_mag_reg;

    logic          num_neg_reg, num_neg_next;
    logic [MW-1:0] num_mag_reg, num_mag_next;
    logic          den_neg_reg, den_neg_next;
    logic [MW-1:0] den_mag_reg, den_mag_next;
    logic          x_neg_reg, x_neg_next;
    logic [MW-1:0] x_mag_reg, x_mag_next;
    logic          y_neg_reg, y_neg_next;
    logic [MW-1:0] y_mag_reg, y_mag_next;
    logic          flag_reg, flag_next;

    logic          add_y_neg;
    logic          sum_neg;
    logic [MW-1:0] sum_mag;
    logic          dz_cond;

    logic [MW-1:0] dvd_in, dvs_in, quo, rem;
    logic          div_done;

    logic [XW-1:0] num_ext, num_tc;
    logic [YW-1:0] den_ext, den_tc;
    logic                 out_valid_reg;
    logic [NUM_OUT_W-1:0] res_num_reg;
    logic [DEN_OUT_W-1:0] res_den_reg;
    logic                 div_zero_reg;

    // Input conversion; a zero denominator is taken as one.
    always_comb
    begin
        an_raw    = a_num;
        ad_raw    = a_den;
        bn_raw    = b_num;
        bd_raw    = b_den;
        an_mag_in = an_raw[W-1] ? (~an_raw + ONE_W) : an_raw;
        ad_mag_in = ad_raw[W-1] ? (~ad_raw + ONE_W) : ad_raw;
        bn_mag_in = bn_raw[W-1] ? (~bn_raw + ONE_W) : bn_raw;
        bd_mag_in = bd_raw[W-1] ? (~bd_raw + ONE_W) : bd_raw;
        if (ad_raw == '0)
        begin
            ad_mag_in = ONE_W;
        end
        if (bd_raw == '0)
        begin
            bd_mag_in = ONE_W;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= cmd_t'(command);
            an_neg_reg <= an_raw[W-1];
            ad_neg_reg <= ad_raw[W-1];
            bn_neg_reg <= bn_raw[W-1];
            bd_neg_reg <= bd_raw[W-1];
            an_mag_reg <= an_mag_in;
            ad_mag_reg <= ad_mag_in;
            bn_mag_reg <= bn_mag_in;
            bd_mag_reg <= bd_mag_in;
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        unique case (cmd.mul_sel)
            MSEL_NUM:
            begin
                op_a_neg = an_neg_reg;
                op_a_mag = an_mag_reg;
                op_b_neg = (cmd_reg == CMD_MUL) ? bn_neg_reg : bd_neg_reg;
                op_b_mag = (cmd_reg == CMD_MUL) ? bn_mag_reg : bd_mag_reg;
            end
            MSEL_DEN:
            begin
                op_a_neg = ad_neg_reg;
                op_a_mag = ad_mag_reg;
                op_b_neg = (cmd_reg == CMD_DIV) ? bn_neg_reg : bd_neg_reg;
                op_b_mag = (cmd_reg == CMD_DIV) ? bn_mag_reg : bd_mag_reg;
            end
            MSEL_CROSS:
            begin
                op_a_neg = ad_neg_reg;
                op_a_mag = ad_mag_reg;
                op_b_neg = bn_neg_reg;
                op_b_mag = bn_mag_reg;
            end
            default:
            begin
                op_a_neg = 1'b0;
                op_a_mag = '0;
                op_b_neg = 1'b0;
                op_b_mag = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_mag_reg <= MW'(op_a_mag) * MW'(op_b_mag);
            prod_nz_reg  <= (|op_a_mag) && (|op_b_mag);
            prod_neg_reg <= (op_a_neg ^ op_b_neg) && (|op_a_mag) && (|op_b_mag);
        end
    end

    // Signed-magnitude add of the numerator and the cross product, negated for a subtract.
    always_comb
    begin
        add_y_neg = prod_neg_reg ^ ((cmd_reg == CMD_SUB) && prod_nz_reg);
        if (num_neg_reg == add_y_neg)
        begin
            sum_mag = num_mag_reg + prod_mag_reg;
            sum_neg = num_neg_reg;
        end
        else if (num_mag_reg >= prod_mag_reg)
        begin
            sum_mag = num_mag_reg - prod_mag_reg;
            sum_neg = num_neg_reg;
        end
        else
        begin
            sum_mag = prod_mag_reg - num_mag_reg;
            sum_neg = add_y_neg;
        end
        sum_neg = sum_neg && (|sum_mag);
    end

    assign dz_cond = (cmd_reg == CMD_DIV) && !(|den_mag_reg);

    always_comb
    begin
        num_neg_next = num_neg_reg;
        num_mag_next = num_mag_reg;
        den_neg_next = den_neg_reg;
        den_mag_next = den_mag_reg;
        x_neg_next   = x_neg_reg;
        x_mag_next   = x_mag_reg;
        y_neg_next   = y_neg_reg;
        y_mag_next   = y_mag_reg;
        flag_next    = flag_reg;

        if (cmd.load)
        begin
            flag_next = 1'b0;
        end
        if (cmd.set_num)
        begin
            num_neg_next = prod_neg_reg;
            num_mag_next = prod_mag_reg;
        end
        if (cmd.set_den)
        begin
            den_neg_next = prod_neg_reg;
            den_mag_next = prod_mag_reg;
        end
        if (cmd.acc && ((cmd_reg == CMD_ADD) || (cmd_reg == CMD_SUB)))
        begin
            num_neg_next = sum_neg;
            num_mag_next = sum_mag;
        end
        if (cmd.chk_zero && dz_cond)
        begin
            num_neg_next = 1'b0;
            num_mag_next = '0;
            den_neg_next = 1'b0;
            den_mag_next = ONE_MW;
            flag_next    = 1'b1;
        end
        if (cmd.gcd_init)
        begin
            x_neg_next = num_neg_reg;
            x_mag_next = num_mag_reg;
            y_neg_next = den_neg_reg;
            y_mag_next = den_mag_reg;
        end
        if (cmd.div_take)
        begin
            unique case (cmd.div_sel)
                DSEL_GCD:
                begin
                    // The remainder keeps the dividend's sign.
                    x_neg_next = y_neg_reg && (|rem);
                    x_mag_next = rem;
                    y_neg_next = x_neg_reg;
                    y_mag_next = x_mag_reg;
                end
                DSEL_NUM:
                begin
                    num_neg_next = (num_neg_reg ^ y_neg_reg) && (|quo);
                    num_mag_next = quo;
                end
                DSEL_DEN:
                begin
                    den_neg_next = (den_neg_reg ^ y_neg_reg) && (|quo);
                    den_mag_next = quo;
                end
                default:
                begin
                    flag_next = flag_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        num_neg_reg <= num_neg_next;
        num_mag_reg <= num_mag_next;
        den_neg_reg <= den_neg_next;
        den_mag_reg <= den_mag_next;
        x_neg_reg   <= x_neg_next;
        x_mag_reg   <= x_mag_next;
        y_neg_reg   <= y_neg_next;
        y_mag_reg   <= y_mag_next;
        flag_reg    <= flag_next;
    end

    // At the end of Euclid's loop y holds the gcd, which then divides both terms.
    always_comb
    begin
        unique case (cmd.div_sel)
            DSEL_GCD:
            begin
                dvd_in = y_mag_reg;
                dvs_in = x_mag_reg;
            end
            DSEL_NUM:
            begin
                dvd_in = num_mag_reg;
                dvs_in = y_mag_reg;
            end
            DSEL_DEN:
            begin
                dvd_in = den_mag_reg;
                dvs_in = y_mag_reg;
            end
            default:
            begin
                dvd_in = '0;
                dvs_in = ONE_MW;
            end
        endcase
    end

    rar_divider #(
        .DIV_WIDTH(MW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_in),
        .divisor  (dvs_in),
        .done     (div_done),
        .quotient (quo),
        .remainder(rem)
    );

    // Output register in two's complement.
    always_comb
    begin
        num_ext = XW'(num_mag_reg);
        den_ext = YW'(den_mag_reg);
        num_tc  = num_neg_reg ? (~num_ext + XW'(1)) : num_ext;
        den_tc  = den_neg_reg ? (~den_ext + YW'(1)) : den_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_num_reg  <= num_tc[NUM_OUT_W-1:0];
            res_den_reg  <= den_tc[DEN_OUT_W-1:0];
            div_zero_reg <= flag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign div_zero  = div_zero_reg;

    assign stat.div_zero = dz_cond;
    assign stat.x_zero   = !(|x_mag_reg);
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

// ===== rtl/core/rar_ctrl.sv =====
// Controller state machine that sequences products, Euclid steps and final divisions.
module rar_ctrl
    import rar_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_MUL_N    = 12'b0000_0000_0010,
        S_SET_N    = 12'b0000_0000_0100,
        S_SET_D    = 12'b0000_0000_1000,
        S_ACC      = 12'b0000_0001_0000,
        S_CHK      = 12'b0000_0010_0000,
        S_GCD_TEST = 12'b0000_0100_0000,
        S_GCD_WAIT = 12'b0000_1000_0000,
        S_QN_WAIT  = 12'b0001_0000_0000,
        S_QD_START = 12'b0010_0000_0000,
        S_QD_WAIT  = 12'b0100_0000_0000,
        S_FIN      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MSEL_NUM;
        cmd.div_sel = DSEL_GCD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_N;
                end
            end
            S_MUL_N:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_NUM;
                state_next  = S_SET_N;
            end
            S_SET_N:
            begin
                cmd.set_num = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_DEN;
                state_next  = S_SET_D;
            end
            S_SET_D:
            begin
                cmd.set_den = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_CROSS;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.div_zero)
                begin
                    cmd.chk_zero = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next   = S_GCD_TEST;
                end
            end
            S_GCD_TEST:
            begin
                cmd.div_start = 1'b1;
                if (stat.x_zero)
                begin
                    cmd.div_sel = DSEL_NUM;
                    state_next  = S_QN_WAIT;
                end
                else
                begin
                    cmd.div_sel = DSEL_GCD;
                    state_next  = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT:
            begin
                cmd.div_sel = DSEL_GCD;
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_GCD_TEST;
                end
            end
            S_QN_WAIT:
            begin
                cmd.div_sel = DSEL_NUM;
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_QD_START;
                end
            end
            S_QD_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_DEN;
                state_next    = S_QD_WAIT;
            end
            S_QD_WAIT:
            begin
                cmd.div_sel = DSEL_DEN;
                if (stat.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ===== rtl/core/rational_arith_reduce.sv =====
// Top level of the rational arithmetic unit with gcd reduction.
//
// The input channel (in_valid/in_ready) carries a command and two fractions
// a_num/a_den and b_num/b_den; the output channel (out_valid/out_ready) carries
// the reduced fraction res_num/res_den and the div_zero flag. One result comes
// out for every input transfer, in order.
// Items are handled one at a time. An item goes through operand capture, the
// three products and the zero check, then through the divider for each Euclid
// remainder step and for the two final divisions, and last loads the output
// register. The radix-2 divider retires one quotient bit per cycle. A divide by
// a zero fraction skips the divider.
// in_ready is high only while the block waits for an item. The result sits in
// an output register, so a new item is accepted while it waits; when the
// receiver stalls and a second result is done, the block holds it until the
// register frees. Reset clears all control state; no result is pending after it.
`include "rational_arith_reduce_macros.svh"

module rational_arith_reduce
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [CMD_W-1:0]                command,
    input  logic signed [OPERAND_WIDTH-1:0] a_num,
    input  logic signed [OPERAND_WIDTH-1:0] a_den,
    input  logic signed [OPERAND_WIDTH-1:0] b_num,
    input  logic signed [OPERAND_WIDTH-1:0] b_den,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [NUM_OUT_W-1:0]     res_num,
    output logic signed [DEN_OUT_W-1:0]     res_den,
    output logic                            div_zero
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    rar_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    rar_datapath #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .command  (command),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .out_ready(out_ready),
        .out_valid(out_valid),
        .res_num  (res_num),
        .res_den  (res_den),
        .div_zero (div_zero)
    );

    // The reduced denominator can never be zero.
    `RAR_ASSERT_IMP(a_den_nonzero, clk, rst_n, out_valid, res_den != '0)
    // A divide by a zero fraction always reports 0/1.
    `RAR_ASSERT_IMP(a_div_zero_result, clk, rst_n, out_valid && div_zero, res_num == '0 && res_den == 32'sd1)
    // After an input transfer the block is busy in the cycle that follows.
    `RAR_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
